FILE: hdl/ilie_pkg.sv
// Shared types and constants of the indexed list block.
// Depends on nothing; the cell, read tree, top level and testbench import it.
package ilie_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // IEEE double encoding of 9999.0, returned by a read out of range.
    localparam logic [63:0] ERR_READ_VALUE = 64'h40C3_8780_0000_0000;

    // Broadcast command seen by every cell of the chain in the same cycle.
    typedef struct packed {
        logic        app;
        logic        ins;
        logic        era;
        logic [6:0]  pos;
        logic [63:0] value;
    } cell_cmd_t;

endpackage

FILE: hdl/ilie_req_if.sv
// Request channel of the indexed list: valid/ready handshake and one operation.
// Depends on nothing.
interface ilie_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [6:0]  position;
    logic [63:0] value;

    modport source (output valid, kind, position, value, input ready);
    modport sink (input valid, kind, position, value, output ready);
endinterface

FILE: hdl/ilie_rsp_if.sv
// Response channel of the indexed list: valid/ready handshake and one result.
// Depends on nothing.
interface ilie_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_value;
    logic [1:0]  status;
    logic [6:0]  count;
    logic        is_empty;

    modport source (output valid, read_value, status, count, is_empty, input ready);
    modport sink (input valid, read_value, status, count, is_empty, output ready);
endinterface

FILE: hdl/ilie_cell.sv
// One entry of the list chain: holds a word and shifts to or from its neighbors.
// Depends on ilie_pkg for the broadcast command type.
module ilie_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic               clk,
    input  ilie_pkg::cell_cmd_t cmd,
    input  logic [CW-1:0]      fill,
    input  logic [63:0]        lower,
    input  logic [63:0]        upper,
    output logic [63:0]        data,
    output logic [63:0]        rd_word
);
    import ilie_pkg::*;

    localparam int W = (CW > 7) ? CW : 7;
    localparam logic [W-1:0] IDX_W = W'(IDX);

    logic [63:0]  data_reg;
    logic [63:0]  data_next;
    logic [W-1:0] pos_w;
    logic [W-1:0] fill_w;

    assign pos_w  = W'(cmd.pos);
    assign fill_w = W'(fill);

    // Insert pulls from the cell below, erase from the cell above.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.app && (IDX_W == fill_w))
        begin
            data_next = cmd.value;
        end
        else if (cmd.ins)
        begin
            if (IDX_W == pos_w)
                data_next = cmd.value;
            else if (IDX_W > pos_w)
                data_next = lower;
        end
        else if (cmd.era && (IDX_W >= pos_w))
        begin
            data_next = upper;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_word = (IDX_W == pos_w) ? data_reg : 64'd0;

endmodule

FILE: hdl/ilie_read_tree.sv
// Two-stage registered OR tree that gathers the one selected cell word.
// Depends on ilie_pkg (imported for house consistency, no types used beyond words).
module ilie_read_tree #(
    parameter int N = 64
) (
    input  logic        clk,
    input  logic        en1,
    input  logic        en2,
    input  logic [63:0] words [N],
    output logic [63:0] result
);
    import ilie_pkg::*;

    localparam int G  = 32;
    localparam int NG = (N + G - 1) / G;

    logic [63:0] grp_reg  [NG];
    logic [63:0] grp_next [NG];
    logic [63:0] sum_reg;
    logic [63:0] sum_next;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = 64'd0;
            for (int j = 0; j < G; j++)
            begin
                if (g * G + j < N)
                    grp_next[g] = grp_next[g] | words[g * G + j];
            end
        end
    end

    always_comb
    begin
        sum_next = 64'd0;
        for (int g = 0; g < NG; g++)
            sum_next = sum_next | grp_reg[g];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int g = 0; g < NG; g++)
                grp_reg[g] <= grp_next[g];
        end
        if (en2)
            sum_reg <= sum_next;
    end

    assign result = sum_reg;

endmodule

FILE: hdl/indexed_list_insert_erase.sv
// Top level of the indexed list: chain of entry cells, read tree and result register.
// Depends on ilie_pkg, ilie_req_if, ilie_rsp_if, ilie_cell and ilie_read_tree.
//
// Usage: each beat on req carries one operation (append, insert at position,
// erase at position, read at position) and produces exactly one beat on rsp
// with the read word, a status, the entry count and an empty flag.
// Insert and erase shift all later entries by one place in the accept cycle;
// every cell moves in parallel with its neighbors.
// The result passes the group level and the sum level of the read OR tree, then
// the output register. The block takes no new operation until the last one has
// left the tree, since every operation passes both registered levels of the
// read OR tree and the load of the output register.
// req.ready is low while an operation is in the tree. A new request is taken
// while a finished result still waits in the output register; when rsp.ready
// stays low, that next result holds at the end of the tree until the output
// register is free.
// Reset clears the entry count and all valid flags; the entry words are not
// cleared and only counted entries are ever returned. No clearing pass.
module indexed_list_insert_erase #(
    parameter int CAPACITY = 64
) (
    input  logic clk,
    input  logic rst_n,
    ilie_req_if.sink   req,
    ilie_rsp_if.source rsp
);
    import ilie_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = (CW > 7) ? CW : 7;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          s1_valid_reg;
    logic          s2_valid_reg;
    logic [1:0]    s1_status_reg;
    logic [1:0]    s2_status_reg;
    logic          s1_read_reg;
    logic          s2_read_reg;
    logic [CW-1:0] s1_count_reg;
    logic [CW-1:0] s2_count_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [63:0]   read_value_reg;
    logic [1:0]    status_reg;
    logic [6:0]    count_reg;
    logic          is_empty_reg;

    logic          accept;
    logic          load;
    logic          full;
    logic [W-1:0]  pos_w;
    logic [W-1:0]  fill_w;
    logic [1:0]    status_now;
    cell_cmd_t     cmd;
    logic [63:0]   tree_word;
    logic [63:0]   cell_data [CAPACITY];
    logic [63:0]   cell_rd   [CAPACITY];

    assign req.ready = !s1_valid_reg && !s2_valid_reg;
    assign accept    = req.valid && req.ready;
    assign load      = s2_valid_reg && (!out_valid_reg || rsp.ready);

    assign full   = (fill_reg == CW'(CAPACITY));
    assign pos_w  = W'(req.position);
    assign fill_w = W'(fill_reg);

    always_comb
    begin
        status_now = ST_DONE;
        cmd.app    = 1'b0;
        cmd.ins    = 1'b0;
        cmd.era    = 1'b0;
        cmd.pos    = req.position;
        cmd.value  = req.value;
        fill_next  = fill_reg;
        case (req.kind)
            KIND_APPEND:
            begin
                if (full)
                    status_now = ST_FULL;
                else
                begin
                    cmd.app   = accept;
                    fill_next = fill_reg + CW'(1);
                end
            end
            KIND_INSERT:
            begin
                if (pos_w > fill_w)
                    status_now = ST_RANGE;
                else if (full)
                    status_now = ST_FULL;
                else
                begin
                    cmd.ins   = accept;
                    fill_next = fill_reg + CW'(1);
                end
            end
            KIND_ERASE:
            begin
                if (pos_w >= fill_w)
                    status_now = ST_RANGE;
                else
                begin
                    cmd.era   = accept;
                    fill_next = fill_reg - CW'(1);
                end
            end
            KIND_READ:
            begin
                if (pos_w >= fill_w)
                    status_now = ST_RANGE;
            end
            default:
            begin
                status_now = ST_DONE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [63:0] lower_w;
            logic [63:0] upper_w;
            if (i == 0)
            begin : g_bot
                assign lower_w = cell_data[0];
            end
            else
            begin : g_mid_lo
                assign lower_w = cell_data[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_top
                assign upper_w = cell_data[CAPACITY-1];
            end
            else
            begin : g_mid_hi
                assign upper_w = cell_data[i+1];
            end
            ilie_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk     (clk),
                .cmd     (cmd),
                .fill    (fill_reg),
                .lower   (lower_w),
                .upper   (upper_w),
                .data    (cell_data[i]),
                .rd_word (cell_rd[i])
            );
        end
    endgenerate

    ilie_read_tree #(
        .N (CAPACITY)
    ) u_tree (
        .clk    (clk),
        .en1    (accept),
        .en2    (s1_valid_reg),
        .words  (cell_rd),
        .result (tree_word)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                fill_reg <= fill_next;
            s1_valid_reg  <= accept;
            if (s1_valid_reg)
                s2_valid_reg <= 1'b1;
            else if (load)
                s2_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_now;
            s1_read_reg   <= (req.kind == KIND_READ);
            s1_count_reg  <= fill_next;
        end
        if (s1_valid_reg)
        begin
            s2_status_reg <= s1_status_reg;
            s2_read_reg   <= s1_read_reg;
            s2_count_reg  <= s1_count_reg;
        end
        if (load)
        begin
            if (!s2_read_reg)
                read_value_reg <= 64'd0;
            else if (s2_status_reg == ST_RANGE)
                read_value_reg <= ERR_READ_VALUE;
            else
                read_value_reg <= tree_word;
            status_reg   <= s2_status_reg;
            count_reg    <= 7'(s2_count_reg);
            is_empty_reg <= (s2_count_reg == '0);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.count      = count_reg;
    assign rsp.is_empty   = is_empty_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_enters_tree: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg && !req.ready)
        else $error("accepted beat did not enter the read tree");

    a_tree_advances: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg && !s1_valid_reg)
        else $error("read tree did not advance");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.kind == KIND_APPEND) && !full)
            |=> (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("append did not raise the entry count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (s2_status_reg == ST_FULL)) |-> (s2_count_reg == CW'(CAPACITY)))
        else $error("full status with list not full");

endmodule

FILE: verif/testbench.sv
// Self-checking bench for the indexed list block: drives operations on the request
// channel and checks every result against an in-bench model of the list.
// Depends on ilie_pkg, ilie_req_if, ilie_rsp_if and indexed_list_insert_erase.
module testbench;
    import ilie_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int SEG_OPS     = 40;
    localparam int SEGMENTS    = 16;
    localparam int RSP_HOLD    = 90;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 12;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  position;
        logic [63:0] value;
    } list_op_t;

    typedef struct packed {
        logic [63:0] read_value;
        logic [1:0]  status;
        logic [6:0]  count;
        logic        is_empty;
    } list_result_t;

    typedef enum { MIX_GROW, MIX_SHRINK, MIX_EVEN } op_mix_t;

    logic clk;
    logic rst_n;

    ilie_req_if req_bus();
    ilie_rsp_if rsp_bus();

    indexed_list_insert_erase #(.CAPACITY(CAPACITY)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Model of the list as seen through accepted beats.
    logic [63:0] list_words [CAPACITY];
    int          list_len = 0;

    list_op_t     queued_ops[$];
    list_result_t awaited_results[$];

    // Length of the list once every queued operation has run; used to aim positions.
    int gen_len = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_kick = 1'b0;
    int   hold_left = 0;
    logic req_beat  = 1'b0;
    int   quiet_cycles = 0;

    int error_count     = 0;
    int results_checked = 0;
    int kind_seen [4]   = '{0, 0, 0, 0};
    int range_errors    = 0;
    int full_refusals   = 0;
    int times_filled    = 0;
    int times_emptied   = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic list_result_t list_apply(list_op_t op);
        list_result_t r;
        int i;
        r.read_value = '0;
        r.status     = ST_DONE;
        case (op.kind)
            KIND_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_len] = op.value;
                    list_len++;
                    if (list_len == CAPACITY)
                        times_filled++;
                end
            end
            KIND_INSERT:
            begin
                if (op.position > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > op.position; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[op.position] = op.value;
                    list_len++;
                    if (list_len == CAPACITY)
                        times_filled++;
                end
            end
            KIND_ERASE:
            begin
                if (op.position >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = op.position; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                    if (list_len == 0)
                        times_emptied++;
                end
            end
            default:
            begin
                if (op.position >= list_len)
                begin
                    r.status     = ST_RANGE;
                    r.read_value = ERR_READ_VALUE;
                end
                else
                    r.read_value = list_words[op.position];
            end
        endcase
        kind_seen[op.kind]++;
        if (r.status == ST_RANGE)
            range_errors++;
        if (r.status == ST_FULL)
            full_refusals++;
        r.count    = 7'(list_len);
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    function automatic int len_after(int len, list_op_t op);
        case (op.kind)
            KIND_APPEND: return (len < CAPACITY) ? len + 1 : len;
            KIND_INSERT: return (op.position <= len && len < CAPACITY) ? len + 1 : len;
            KIND_ERASE:  return (op.position < len) ? len - 1 : len;
            default:     return len;
        endcase
    endfunction

    // Mostly operations aimed at valid positions of the list as it will be,
    // with a share of unconstrained noise that also sets the high position bit.
    function automatic list_op_t make_op(op_mix_t mix);
        list_op_t op;
        int roll;
        int w_app;
        int w_ins;
        int w_era;
        op.value = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 5)
            op.value = '1;
        else if (roll < 10)
            op.value = '0;
        if ($urandom_range(99) < 10)
        begin
            op.kind     = 2'($urandom_range(3));
            op.position = 7'($urandom_range(127));
            return op;
        end
        case (mix)
            MIX_GROW:
            begin
                w_app = 40;
                w_ins = 40;
                w_era = 5;
            end
            MIX_SHRINK:
            begin
                w_app = 5;
                w_ins = 5;
                w_era = 70;
            end
            default:
            begin
                w_app = 25;
                w_ins = 25;
                w_era = 25;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < w_app)
            op.kind = KIND_APPEND;
        else if (roll < w_app + w_ins)
            op.kind = KIND_INSERT;
        else if (roll < w_app + w_ins + w_era)
            op.kind = KIND_ERASE;
        else
            op.kind = KIND_READ;
        case (op.kind)
            KIND_APPEND: op.position = 7'($urandom_range(127));
            KIND_INSERT: op.position = 7'($urandom_range(gen_len));
            default:     op.position = (gen_len == 0) ? 7'd0 : 7'($urandom_range(gen_len - 1));
        endcase
        return op;
    endfunction

    task automatic queue_op(logic [1:0] kind, logic [6:0] position, logic [63:0] value);
        list_op_t op;
        op.kind     = kind;
        op.position = position;
        op.value    = value;
        queued_ops.insert(queued_ops.size(), op);
        gen_len = len_after(gen_len, op);
    endtask

    task automatic log_failure(string what, list_result_t want, list_result_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR %s at %0t: expected value=%h status=%0d count=%0d empty=%0b",
                     what, $time, want.read_value, want.status, want.count, want.is_empty);
            $display("    got value=%h status=%0d count=%0d empty=%0b",
                     got.read_value, got.status, got.count, got.is_empty);
        end
    endtask

    // Request driver: a beat on offer stays unchanged until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && !(req_bus.valid && !req_beat))
        begin
            if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_bus.valid    <= 1'b1;
                req_bus.kind     <= queued_ops[0].kind;
                req_bus.position <= queued_ops[0].position;
                req_bus.value    <= queued_ops[0].value;
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
            rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold-off, started by a one-cycle kick from the stimulus.
    always @(posedge clk)
    begin
        if (hold_kick)
            hold_left <= RSP_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin : req_monitor
        list_op_t op;
        req_beat <= rst_n && req_bus.valid && req_bus.ready;
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            op.kind     = req_bus.kind;
            op.position = req_bus.position;
            op.value    = req_bus.value;
            queued_ops.delete(0);
            awaited_results.insert(awaited_results.size(), list_apply(op));
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        list_result_t got;
        list_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.read_value = rsp_bus.read_value;
            got.status     = rsp_bus.status;
            got.count      = rsp_bus.count;
            got.is_empty   = rsp_bus.is_empty;
            if (awaited_results.size() == 0)
                log_failure("unexpected result", got, got);
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (got.read_value !== want.read_value || got.status !== want.status ||
                    got.count !== want.count || got.is_empty !== want.is_empty)
                    log_failure("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, awaited_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        list_op_t op;
        op_mix_t  mix;
        int       phase;
        int       seg;
        int       n;

        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.kind     = KIND_APPEND;
        req_bus.position = '0;
        req_bus.value    = '0;
        rsp_bus.ready    = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Empty list: every positional operation is out of range.
        queue_op(KIND_READ,   7'd0,   64'd0);
        queue_op(KIND_ERASE,  7'd0,   64'd0);
        queue_op(KIND_INSERT, 7'd1,   64'h1111_2222_3333_4444);
        queue_op(KIND_READ,   7'd127, 64'd0);
        // Insert into the empty list, append twice, then insert at the end, the front and the middle.
        queue_op(KIND_INSERT, 7'd0,   '1);
        queue_op(KIND_APPEND, 7'd0,   64'd0);
        queue_op(KIND_APPEND, 7'd127, 64'h8000_0000_0000_0001);
        queue_op(KIND_INSERT, 7'd3,   64'hA5A5_A5A5_A5A5_A5A5);
        queue_op(KIND_INSERT, 7'd0,   64'h5A5A_5A5A_5A5A_5A5A);
        queue_op(KIND_INSERT, 7'd2,   64'h0123_4567_89AB_CDEF);
        // Reads at the first and last entries, just past the end and far beyond it.
        queue_op(KIND_READ,   7'd0,   64'd0);
        queue_op(KIND_READ,   7'd5,   '1);
        queue_op(KIND_READ,   7'd6,   64'd0);
        queue_op(KIND_READ,   7'd64,  64'd0);
        // Erase at the end, the front and the middle, then one past the end.
        queue_op(KIND_ERASE,  7'd5,   64'd0);
        queue_op(KIND_ERASE,  7'd0,   64'd0);
        queue_op(KIND_ERASE,  7'd1,   64'd0);
        queue_op(KIND_ERASE,  7'd3,   64'd0);
        queue_op(KIND_INSERT, 7'd4,   64'hDEAD_BEEF_0000_0001);
        queue_op(KIND_INSERT, 7'd127, 64'hDEAD_BEEF_0000_0002);
        queue_op(KIND_ERASE,  7'd127, 64'd0);
        queue_op(KIND_READ,   7'd2,   64'd0);

        for (phase = 0; phase < 3; phase++)
        begin
            while (queued_ops.size() != 0 || awaited_results.size() != 0)
                @(posedge clk);
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Rounds of growing, even and shrinking segments, aimed at filling the list and emptying it again.
            for (seg = 0; seg < SEGMENTS; seg++)
            begin
                case (seg % 8)
                    0, 1, 2: mix = MIX_GROW;
                    4, 5, 6: mix = MIX_SHRINK;
                    default: mix = MIX_EVEN;
                endcase
                while (queued_ops.size() > 8)
                    @(posedge clk);
                for (n = 0; n < SEG_OPS; n++)
                begin
                    op = make_op(mix);
                    queue_op(op.kind, op.position, op.value);
                end
                // With a full queue behind it, a long receiver stall backs up the block.
                if (phase == 0 && seg == 2)
                begin
                    @(posedge clk);
                    hold_kick <= 1'b1;
                    @(posedge clk);
                    hold_kick <= 1'b0;
                end
            end
        end

        while (queued_ops.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        error_count += awaited_results.size();

        $display("Checked %0d results: %0d appends, %0d inserts, %0d erases, %0d reads.",
                 results_checked, kind_seen[KIND_APPEND], kind_seen[KIND_INSERT],
                 kind_seen[KIND_ERASE], kind_seen[KIND_READ]);
        $display("List filled %0d times and emptied %0d times; %0d range and %0d full refusals.",
                 times_filled, times_emptied, range_errors, full_refusals);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ilie_pkg.sv
hdl/ilie_req_if.sv
hdl/ilie_rsp_if.sv
hdl/ilie_cell.sv
hdl/ilie_read_tree.sv
hdl/indexed_list_insert_erase.sv
verif/testbench.sv
